// ----- rtl/mtds_pkg.sv -----
// shared types and constants of the multi timer deadline scheduler
`timescale 1ns / 1ps
`default_nettype none
package mtds_pkg;

    // command codes
    localparam logic [2:0] CMD_CFG   = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_CHECK = 3'd3;
    localparam logic [2:0] CMD_SHIFT = 3'd4;

    // result codes
    localparam logic [1:0] EV_DONE    = 2'd0;
    localparam logic [1:0] EV_EXPIRED = 2'd1;
    localparam logic [1:0] EV_ALARM   = 2'd2;
    localparam logic [1:0] EV_STOPPED = 2'd3;

    // register indexes
    localparam logic REG_MIN_FINE   = 1'b0;
    localparam logic REG_MIN_COARSE = 1'b1;

    // register reset values
    localparam logic [15:0] MIN_FINE_RST   = 16'd3;
    localparam logic [15:0] MIN_COARSE_RST = 16'd1;

    // slot flag bit positions
    localparam int FL_RUN = 0;
    localparam int FL_GRP = 1;
    localparam int FL_PER = 2;
    localparam int FL_ABS = 3;
    localparam int FL_ACT = 4;
    localparam int FL_OUT = 5;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  timer_id;
        logic        group;
        logic [31:0] now_fine;
        logic [31:0] now_coarse;
        logic [31:0] period;
        logic        is_periodic;
        logic        is_absolute;
        logic        has_action;
        logic        shift_positive;
        logic [31:0] shift_fine;
        logic [31:0] shift_coarse;
    } t_in;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [3:0]  event_timer;
        logic        event_group;
        logic [31:0] alarm_delay;
        logic        last;
    } t_out;

    // operation broadcast to the cells
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_CFG   = 3'd1,
        OP_BEGIN = 3'd2,
        OP_STOP  = 3'd3,
        OP_MARK  = 3'd4,
        OP_SHIFT = 3'd5
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] now;
        logic        grp;
        logic        excl;
        logic [31:0] tmo;
        logic [31:0] period;
        logic        per;
        logic        abs;
        logic        act;
        logic        fwd;
        logic [31:0] sh_fine;
        logic [31:0] sh_coarse;
    } t_ctl;

    // running minimum handed along the cell row
    typedef struct packed {
        logic        any;
        logic [31:0] min;
    } t_link;

    typedef struct packed {
        logic        run;
        logic        grp;
        logic        per;
        logic        abs;
        logic        act;
        logic        hit;
        logic [31:0] left;
        logic [31:0] period;
    } t_sts;

endpackage
`default_nettype wire

// ----- rtl/mtds_mod.sv -----
// bit-serial remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module mtds_mod (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_p,
    output logic             o_busy,
    output logic             o_done,
    output logic [31:0]      o_rem
);
    logic [31:0] r_a;
    logic [31:0] r_p;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_try;

    // shift in next dividend bit
    assign n_try = {r_rem[31:0], r_a[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_p    <= i_p;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_a <= {r_a[30:0], 1'b0};
                if (n_try >= {1'b0, r_p}) begin
                    r_rem <= n_try - {1'b0, r_p};
                end else begin
                    r_rem <= n_try;
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_rem[31:0];
endmodule
`default_nettype wire

// ----- rtl/mtds_cell.sv -----
// one timer slot with its stage of the running minimum row
`timescale 1ns / 1ps
`default_nettype none
module mtds_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mtds_pkg::t_ctl  i_ctl,
    input  wire logic            i_me,
    input  wire mtds_pkg::t_link i_prev,
    output mtds_pkg::t_link      o_next,
    output mtds_pkg::t_sts       o_sts
);
    logic [31:0]     r_period;
    logic [31:0]     r_timeout;
    logic [31:0]     r_ref;
    logic [5:0]      r_flags;
    logic [31:0]     r_left;
    logic            r_v;
    mtds_pkg::t_link r_next;
    logic [31:0]     elapsed;
    logic [31:0]     left;
    logic            in_grp;
    logic [31:0]     sh;

    // remaining time and expiry at the broadcast time
    assign elapsed = i_ctl.now - r_ref;
    assign left    = (elapsed <= r_timeout) ? (r_timeout - elapsed) : 32'd0;
    assign in_grp  = r_flags[mtds_pkg::FL_RUN] && (r_flags[mtds_pkg::FL_GRP] == i_ctl.grp);
    assign sh      = r_flags[mtds_pkg::FL_GRP] ? i_ctl.sh_coarse : i_ctl.sh_fine;

    // slot state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= '0;
            r_timeout <= '0;
            r_ref     <= '0;
            r_flags   <= '0;
        end else begin
            case (i_ctl.op)
                mtds_pkg::OP_CFG: begin
                    if (i_me) begin
                        r_flags   <= {1'b0, i_ctl.act, i_ctl.abs, i_ctl.per, i_ctl.grp, 1'b0};
                        r_period  <= i_ctl.period;
                        r_timeout <= i_ctl.period;
                    end
                end
                mtds_pkg::OP_BEGIN: begin
                    if (i_me) begin
                        r_flags[mtds_pkg::FL_OUT] <= 1'b0;
                        r_flags[mtds_pkg::FL_RUN] <= 1'b1;
                        r_ref     <= i_ctl.now;
                        r_timeout <= i_ctl.tmo;
                    end
                end
                mtds_pkg::OP_STOP: begin
                    if (i_me) begin
                        r_flags[mtds_pkg::FL_RUN] <= 1'b0;
                    end
                end
                mtds_pkg::OP_MARK: begin
                    if (in_grp && (elapsed >= r_timeout)) begin
                        r_flags[mtds_pkg::FL_RUN] <= 1'b0;
                        r_flags[mtds_pkg::FL_OUT] <= 1'b1;
                    end
                end
                mtds_pkg::OP_SHIFT: begin
                    if (r_flags[mtds_pkg::FL_RUN]) begin
                        r_ref <= i_ctl.fwd ? (r_ref + sh) : (r_ref - sh);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // register own contribution, then fold into the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v        <= 1'b0;
            r_next.any <= 1'b0;
        end else begin
            r_v        <= in_grp && !(i_ctl.excl && i_me);
            r_next.any <= i_prev.any || r_v;
        end
        r_left <= left;
        if (!i_prev.any || (r_v && (r_left < i_prev.min))) begin
            r_next.min <= r_left;
        end else begin
            r_next.min <= i_prev.min;
        end
    end

    assign o_next       = r_next;
    assign o_sts.run    = r_flags[mtds_pkg::FL_RUN];
    assign o_sts.grp    = r_flags[mtds_pkg::FL_GRP];
    assign o_sts.per    = r_flags[mtds_pkg::FL_PER];
    assign o_sts.abs    = r_flags[mtds_pkg::FL_ABS];
    assign o_sts.act    = r_flags[mtds_pkg::FL_ACT];
    assign o_sts.hit    = in_grp && (elapsed >= r_timeout);
    assign o_sts.left   = r_left;
    assign o_sts.period = r_period;
endmodule
`default_nettype wire

// ----- rtl/multi_timer_deadline_scheduler_unit.sv -----
// Configure and ignored commands do not use the slot row; start/stop/check/shift pass the
// slot row once per schedule, plus a run of the serial remainder unit for every absolute
// start or absolute periodic restart. Check also walks the slots twice, slot by slot;
// one command at a time.
// A result waits in an output register; a further result stalls until the waiting one is taken.
// Reset (synchronous, active low) clears all slots and loads min delays 3 and 1.
`timescale 1ns / 1ps
`default_nettype none
module multi_timer_deadline_scheduler_unit #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mtds_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output mtds_pkg::t_out      o_out,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_idx,
    input  wire logic [15:0]    i_cfg_data
);
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 4);

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_CFG       = 14'b00000000000010,
        S_MOD       = 14'b00000000000100,
        S_BEGIN     = 14'b00000000001000,
        S_CHAIN     = 14'b00000000010000,
        S_START_DEC = 14'b00000000100000,
        S_STOP      = 14'b00000001000000,
        S_MARK      = 14'b00000010000000,
        S_SCAN      = 14'b00000100000000,
        S_RST       = 14'b00001000000000,
        S_SCHED     = 14'b00010000000000,
        S_SHIFT     = 14'b00100000000000,
        S_NEXTG     = 14'b01000000000000,
        S_EMIT      = 14'b10000000000000
    } t_state;

    t_state          r_state;
    t_state          r_ret;
    mtds_pkg::t_in   r_in;
    logic [15:0]     r_min0;
    logic [15:0]     r_min1;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_cnt;
    logic [31:0]     r_now;
    logic            r_g;
    logic            r_excl;
    logic [31:0]     r_t;
    logic            r_cfg_ok;
    logic            r_mod_go;
    logic [NUM_TIMERS-1:0] r_rep;
    logic [NUM_TIMERS-1:0] r_rper;
    mtds_pkg::t_out  r_pend;
    mtds_pkg::t_out  r_out;
    logic            r_ov;

    mtds_pkg::t_ctl  ctl;
    mtds_pkg::t_link link [NUM_TIMERS+1];
    mtds_pkg::t_sts  sts [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] v_run_g;
    logic [NUM_TIMERS-1:0] v_hit;
    logic [NUM_TIMERS-1:0] v_per;
    logic [NUM_TIMERS-1:0] v_act;
    logic [IW-1:0]   sel;
    logic [IW-1:0]   id_sel;
    logic            id_ok;
    logic [31:0]     mind;
    logic [31:0]     p1;
    logic            mod_busy;
    logic            mod_done;
    logic [31:0]     mod_rem;
    logic [31:0]     best;
    logic [31:0]     mine;
    mtds_pkg::t_in   in_v;

    assign in_v   = i_in;
    assign sel    = r_idx[IW-1:0];
    assign id_sel = IW'(in_v.timer_id);
    assign id_ok  = (32'(in_v.timer_id) < NUM_TIMERS);
    assign mind   = r_g ? 32'(r_min1) : 32'(r_min0);
    assign p1     = (sts[sel].period == 32'd0) ? 32'd1 : sts[sel].period;
    assign best   = (link[NUM_TIMERS].min < mind) ? mind : link[NUM_TIMERS].min;
    assign mine   = sts[sel].left;

    // broadcast to the slot row
    always_comb begin
        ctl.now       = r_now;
        ctl.grp       = r_g;
        ctl.excl      = r_excl;
        ctl.tmo       = r_t;
        ctl.period    = r_in.period;
        ctl.per       = r_in.is_periodic;
        ctl.abs       = r_in.is_absolute;
        ctl.act       = r_in.has_action;
        ctl.fwd       = r_in.shift_positive;
        ctl.sh_fine   = r_in.shift_fine;
        ctl.sh_coarse = r_in.shift_coarse;
        unique case (r_state)
            S_CFG:   ctl.op = r_cfg_ok ? mtds_pkg::OP_CFG : mtds_pkg::OP_NONE;
            S_BEGIN: ctl.op = mtds_pkg::OP_BEGIN;
            S_STOP:  ctl.op = mtds_pkg::OP_STOP;
            S_MARK:  ctl.op = mtds_pkg::OP_MARK;
            S_SHIFT: ctl.op = mtds_pkg::OP_SHIFT;
            default: ctl.op = mtds_pkg::OP_NONE;
        endcase
    end

    // row of slot cells
    assign link[0] = '0;
    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
        mtds_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_me    (r_idx == CW'(k)),
            .i_prev  (link[k]),
            .o_next  (link[k+1]),
            .o_sts   (sts[k])
        );
        assign v_run_g[k] = sts[k].run && (sts[k].grp == in_v.group);
        assign v_hit[k]   = sts[k].hit;
        assign v_per[k]   = sts[k].per;
        assign v_act[k]   = sts[k].act;
    end

    mtds_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mod_go),
        .i_a     (r_now),
        .i_p     (p1),
        .o_busy  (mod_busy),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min0 <= mtds_pkg::MIN_FINE_RST;
            r_min1 <= mtds_pkg::MIN_COARSE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == mtds_pkg::REG_MIN_FINE) begin
                r_min0 <= i_cfg_data;
            end else begin
                r_min1 <= i_cfg_data;
            end
        end
    end

    // command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ov     <= 1'b0;
            r_mod_go <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_excl   <= 1'b0;
            r_g      <= 1'b0;
        end else begin
            r_mod_go <= 1'b0;
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in   <= in_v;
                        r_pend <= '{event_res: mtds_pkg::EV_DONE, event_timer: 4'd0,
                                    event_group: 1'b0, alarm_delay: 32'd0, last: 1'b1};
                        r_ret  <= S_IDLE;
                        r_state <= S_EMIT;
                        case (in_v.cmd)
                            mtds_pkg::CMD_CFG: begin
                                r_cfg_ok <= id_ok && !sts[id_sel].run;
                                r_g      <= in_v.group;
                                r_idx    <= CW'(in_v.timer_id);
                                r_state  <= S_CFG;
                            end
                            mtds_pkg::CMD_START: begin
                                if (id_ok && !sts[id_sel].run) begin
                                    r_idx <= CW'(in_v.timer_id);
                                    r_g   <= sts[id_sel].grp;
                                    r_now <= sts[id_sel].grp ? in_v.now_coarse : in_v.now_fine;
                                    if (sts[id_sel].abs) begin
                                        r_mod_go <= 1'b1;
                                        r_state  <= S_MOD;
                                    end else begin
                                        r_t     <= sts[id_sel].period;
                                        r_state <= S_BEGIN;
                                    end
                                end
                            end
                            mtds_pkg::CMD_STOP: begin
                                if (id_ok && sts[id_sel].run) begin
                                    r_idx   <= CW'(in_v.timer_id);
                                    r_g     <= sts[id_sel].grp;
                                    r_now   <= sts[id_sel].grp ? in_v.now_coarse : in_v.now_fine;
                                    r_excl  <= 1'b1;
                                    r_cnt   <= '0;
                                    r_ret   <= S_STOP;
                                    r_state <= S_CHAIN;
                                end
                            end
                            mtds_pkg::CMD_CHECK: begin
                                if (|v_run_g) begin
                                    r_g     <= in_v.group;
                                    r_now   <= in_v.group ? in_v.now_coarse : in_v.now_fine;
                                    r_excl  <= 1'b0;
                                    r_state <= S_MARK;
                                end
                            end
                            mtds_pkg::CMD_SHIFT: begin
                                r_excl  <= 1'b0;
                                r_state <= S_SHIFT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CFG: begin
                    r_state <= S_EMIT;
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_t     <= p1 - mod_rem;
                        r_state <= S_BEGIN;
                    end
                end
                S_BEGIN: begin
                    if (r_in.cmd == mtds_pkg::CMD_START) begin
                        r_excl  <= 1'b1;
                        r_cnt   <= '0;
                        r_ret   <= S_START_DEC;
                        r_state <= S_CHAIN;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_RST;
                    end
                end
                S_CHAIN: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(NUM_TIMERS + 3)) begin
                        r_state <= r_ret;
                    end
                end
                S_START_DEC: begin
                    // new slot leads its group when no other is at or below it
                    r_ret   <= S_IDLE;
                    r_state <= S_EMIT;
                    if (!link[NUM_TIMERS].any || (link[NUM_TIMERS].min > r_t)) begin
                        r_pend <= '{event_res: mtds_pkg::EV_ALARM, event_timer: 4'd0,
                                    event_group: r_g,
                                    alarm_delay: (r_t < mind) ? mind : r_t, last: 1'b1};
                    end
                end
                S_STOP: begin
                    // stopped slot held the minimum when none of the others is below it
                    r_ret   <= S_IDLE;
                    r_state <= S_EMIT;
                    if (!link[NUM_TIMERS].any) begin
                        r_pend <= '{event_res: mtds_pkg::EV_STOPPED, event_timer: 4'd0,
                                    event_group: r_g, alarm_delay: 32'd0, last: 1'b1};
                    end else if (link[NUM_TIMERS].min >= mine) begin
                        r_pend <= '{event_res: mtds_pkg::EV_ALARM, event_timer: 4'd0,
                                    event_group: r_g, alarm_delay: best, last: 1'b1};
                    end
                end
                S_MARK: begin
                    r_rep   <= v_hit & (v_per | v_act);
                    r_rper  <= v_hit & v_per;
                    r_idx   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // report expired periodic or action slots in slot order
                    if (r_idx == CW'(NUM_TIMERS)) begin
                        r_idx   <= '0;
                        r_state <= S_RST;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                        if (r_rep[sel]) begin
                            r_pend  <= '{event_res: mtds_pkg::EV_EXPIRED,
                                        event_timer: 4'(r_idx), event_group: r_g,
                                        alarm_delay: 32'd0, last: 1'b0};
                            r_ret   <= S_SCAN;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_RST: begin
                    // restart periodic slots that expired
                    if (r_idx == CW'(NUM_TIMERS)) begin
                        r_cnt   <= '0;
                        r_ret   <= S_SCHED;
                        r_state <= S_CHAIN;
                    end else if (r_rper[sel]) begin
                        if (sts[sel].abs) begin
                            r_mod_go <= 1'b1;
                            r_state  <= S_MOD;
                        end else begin
                            r_t     <= sts[sel].period;
                            r_state <= S_BEGIN;
                        end
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_SCHED: begin
                    r_state <= S_EMIT;
                    if ((r_in.cmd == mtds_pkg::CMD_SHIFT) && !r_g) begin
                        r_ret <= S_NEXTG;
                    end else begin
                        r_ret <= S_IDLE;
                    end
                    if (!link[NUM_TIMERS].any) begin
                        r_pend <= '{event_res: mtds_pkg::EV_STOPPED, event_timer: 4'd0,
                                    event_group: r_g, alarm_delay: 32'd0,
                                    last: !((r_in.cmd == mtds_pkg::CMD_SHIFT) && !r_g)};
                    end else begin
                        r_pend <= '{event_res: mtds_pkg::EV_ALARM, event_timer: 4'd0,
                                    event_group: r_g, alarm_delay: best,
                                    last: !((r_in.cmd == mtds_pkg::CMD_SHIFT) && !r_g)};
                    end
                end
                S_SHIFT: begin
                    r_g     <= 1'b0;
                    r_now   <= r_in.now_fine;
                    r_cnt   <= '0;
                    r_ret   <= S_SCHED;
                    r_state <= S_CHAIN;
                end
                S_NEXTG: begin
                    r_g     <= 1'b1;
                    r_now   <= r_in.now_coarse;
                    r_cnt   <= '0;
                    r_ret   <= S_SCHED;
                    r_state <= S_CHAIN;
                end
                S_EMIT: begin
                    if (!r_ov || i_out_ready) begin
                        r_out   <= r_pend;
                        r_ov    <= 1'b1;
                        r_state <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    // remainder unit is never left running while a new request can enter
    a_mod_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mod_busy)
        else $error("remainder unit busy while idle");

    // row settle wait stays within its bound
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHAIN) |-> (r_cnt <= CW'(NUM_TIMERS + 3)))
        else $error("row wait counter overran");

    // a final result always returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && r_pend.last) |-> (r_ret == S_IDLE))
        else $error("final result does not end the request");

    // remainder start only from a state that waits for it
    a_mod_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod_go |-> (r_state == S_MOD))
        else $error("remainder start outside its wait state");
endmodule
`default_nettype wire

// ----- tb/mtds_sched_checker.sv -----
// timer table predictor and result comparison for the deadline scheduler testbench
`timescale 1ns / 1ps
`default_nettype none
module mtds_sched_checker
    import mtds_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire t_in         i_in,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire t_out        i_out,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output int               o_pending,
    output int               o_errors
);

    // shadow copy of the slot table and min delays
    logic [31:0] slot_per [NUM_TIMERS];
    logic [31:0] slot_tmo [NUM_TIMERS];
    logic [31:0] slot_ref [NUM_TIMERS];
    logic [5:0]  slot_flg [NUM_TIMERS];
    logic [31:0] min_fine;
    logic [31:0] min_coarse;

    t_out event_q[$];
    int   err_cnt = 0;

    assign o_errors = err_cnt;

    // time a slot has left at a given time, zero once overdue
    function automatic logic [31:0] time_left(int i, logic [31:0] now);
        logic [31:0] el;
        el = now - slot_ref[i];
        return (el <= slot_tmo[i]) ? slot_tmo[i] - el : 32'd0;
    endfunction

    function automatic bit running_in(int i, logic g);
        return slot_flg[i][FL_RUN] && (slot_flg[i][FL_GRP] == g);
    endfunction

    function automatic void add_event(logic [1:0] res, logic [3:0] tm, logic g,
                                      logic [31:0] d);
        t_out ev;
        ev.event_res   = res;
        ev.event_timer = tm;
        ev.event_group = g;
        ev.alarm_delay = d;
        ev.last        = 1'b0;
        event_q.push_back(ev);
    endfunction

    // nearest deadline of a group, clamped to its min delay; stopped when none runs
    function automatic void add_alarm(logic g, logic [31:0] now);
        bit          any;
        logic [31:0] best;
        logic [31:0] lim;
        logic [31:0] r;
        any  = 0;
        best = '0;
        lim  = g ? min_coarse : min_fine;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (running_in(i, g)) begin
                r = time_left(i, now);
                if (!any || r < best) best = r;
                any = 1;
            end
        end
        if (!any) begin
            add_event(EV_STOPPED, 4'd0, g, 32'd0);
        end else begin
            if (best < lim) best = lim;
            add_event(EV_ALARM, 4'd0, g, best);
        end
    endfunction

    function automatic void launch_slot(int i, logic [31:0] now);
        logic [31:0] t;
        logic [31:0] p;
        t = slot_per[i];
        if (slot_flg[i][FL_ABS]) begin
            p = (t != 0) ? t : 32'd1;
            t = p - now % p;
        end
        slot_flg[i][FL_OUT] = 1'b0;
        slot_flg[i][FL_RUN] = 1'b1;
        slot_ref[i] = now;
        slot_tmo[i] = t;
    endfunction

    // expected events for one accepted request
    function automatic void predict_events(t_in rq);
        int          n0;
        int          id;
        logic        sg;
        logic [31:0] now;
        logic [31:0] mine;
        bit          front;
        bit          any;
        bit          hit [NUM_TIMERS];
        t_out        tail;
        n0 = event_q.size();
        id = rq.timer_id;
        if ((rq.cmd == CMD_CFG || rq.cmd == CMD_START || rq.cmd == CMD_STOP)
                && id < NUM_TIMERS) begin
            sg  = slot_flg[id][FL_GRP];
            now = sg ? rq.now_coarse : rq.now_fine;
            if (rq.cmd == CMD_CFG) begin
                if (!slot_flg[id][FL_RUN]) begin
                    slot_flg[id] = '0;
                    slot_flg[id][FL_GRP] = rq.group;
                    slot_flg[id][FL_PER] = rq.is_periodic;
                    slot_flg[id][FL_ABS] = rq.is_absolute;
                    slot_flg[id][FL_ACT] = rq.has_action;
                    slot_per[id] = rq.period;
                    slot_tmo[id] = rq.period;
                end
            end else if (rq.cmd == CMD_START) begin
                if (!slot_flg[id][FL_RUN]) begin
                    launch_slot(id, now);
                    front = 1;
                    for (int i = 0; i < NUM_TIMERS; i++)
                        if (i != id && running_in(i, sg) && time_left(i, now) <= slot_tmo[id])
                            front = 0;
                    if (front) add_alarm(sg, now);
                end
            end else begin
                if (slot_flg[id][FL_RUN]) begin
                    mine  = time_left(id, now);
                    front = 1;
                    for (int i = 0; i < NUM_TIMERS; i++)
                        if (i != id && running_in(i, sg) && time_left(i, now) < mine)
                            front = 0;
                    slot_flg[id][FL_RUN] = 1'b0;
                    if (front) add_alarm(sg, now);
                end
            end
        end else if (rq.cmd == CMD_CHECK) begin
            now = rq.group ? rq.now_coarse : rq.now_fine;
            any = 0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                hit[i] = 0;
                if (running_in(i, rq.group)) begin
                    any = 1;
                    if (now - slot_ref[i] >= slot_tmo[i]) begin
                        hit[i] = 1;
                        slot_flg[i][FL_RUN] = 1'b0;
                        slot_flg[i][FL_OUT] = 1'b1;
                        if (slot_flg[i][FL_PER] || slot_flg[i][FL_ACT])
                            add_event(EV_EXPIRED, 4'(i), rq.group, 32'd0);
                    end
                end
            end
            if (any) begin
                for (int i = 0; i < NUM_TIMERS; i++)
                    if (hit[i] && slot_flg[i][FL_PER]) launch_slot(i, now);
                add_alarm(rq.group, now);
            end
        end else if (rq.cmd == CMD_SHIFT) begin
            for (int q = 0; q < 2; q++) begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (running_in(i, 1'(q))) begin
                        if (rq.shift_positive)
                            slot_ref[i] += (q != 0) ? rq.shift_coarse : rq.shift_fine;
                        else
                            slot_ref[i] -= (q != 0) ? rq.shift_coarse : rq.shift_fine;
                    end
                end
                add_alarm(1'(q), (q != 0) ? rq.now_coarse : rq.now_fine);
            end
        end
        if (event_q.size() == n0) add_event(EV_DONE, 4'd0, 1'b0, 32'd0);
        tail = event_q.pop_back();
        tail.last = 1'b1;
        event_q.push_back(tail);
    endfunction

    function automatic void compare_event(t_out got);
        t_out exp_ev;
        if (event_q.size() == 0) begin
            $error("unexpected result res=%0d timer=%0d", got.event_res, got.event_timer);
            err_cnt++;
            return;
        end
        exp_ev = event_q.pop_front();
        if (got.event_res !== exp_ev.event_res) begin
            $error("event_res: expected %0d, got %0d", exp_ev.event_res, got.event_res);
            err_cnt++;
        end
        if (got.event_timer !== exp_ev.event_timer) begin
            $error("event_timer: expected %0d, got %0d", exp_ev.event_timer, got.event_timer);
            err_cnt++;
        end
        if (got.event_group !== exp_ev.event_group) begin
            $error("event_group: expected %0d, got %0d", exp_ev.event_group, got.event_group);
            err_cnt++;
        end
        if (got.alarm_delay !== exp_ev.alarm_delay) begin
            $error("alarm_delay: expected %0d, got %0d", exp_ev.alarm_delay, got.alarm_delay);
            err_cnt++;
        end
        if (got.last !== exp_ev.last) begin
            $error("last: expected %0d, got %0d", exp_ev.last, got.last);
            err_cnt++;
        end
    endfunction

    // watch config writes, the request channel and the result channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                slot_per[i] = '0;
                slot_tmo[i] = '0;
                slot_ref[i] = '0;
                slot_flg[i] = '0;
            end
            min_fine   = 32'(MIN_FINE_RST);
            min_coarse = 32'(MIN_COARSE_RST);
            event_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MIN_FINE) min_fine = 32'(i_cfg_data);
                else min_coarse = 32'(i_cfg_data);
            end
            if (i_out_valid && i_out_ready) compare_event(i_out);
            if (i_in_valid && i_in_ready) predict_events(i_in);
        end
        o_pending <= event_q.size();
    end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// stimulus, handshake pacing and verdict for the deadline scheduler
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import mtds_pkg::*;

    localparam int RUN_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in         in_req = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_ev;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [15:0] cfg_data = '0;
    int          pending;
    int          errors;

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          hold_cnt = 0;
    logic [31:0] tick_fine = 32'd100;
    logic [31:0] tick_coarse = 32'd10;

    // clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    multi_timer_deadline_scheduler_unit #(.NUM_TIMERS(16)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_req),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_ev),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    mtds_sched_checker #(.NUM_TIMERS(16)) u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in(in_req),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out(out_ev),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_pending(pending), .o_errors(errors)
    );

    // receiver: random stalls plus a long hold-off when the stimulus asks for one
    always @(posedge clk) begin
        if (hold_cnt > 0) begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt - 1;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_cnt  <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // run limit
    initial begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("FAIL multi_timer_deadline_scheduler_unit");
        $finish;
    end

    // offer one request and hold it until taken
    task automatic send_req(t_in rq);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= rq;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_min_delays(logic [15:0] fine, logic [15:0] coarse);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_MIN_FINE;
        cfg_data <= fine;
        @(posedge clk);
        cfg_idx  <= REG_MIN_COARSE;
        cfg_data <= coarse;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // request with random filler, current times and the given command fields
    function automatic t_in mk_req(logic [2:0] cmd, logic [3:0] id, logic grp,
                                   logic [31:0] per, logic p, logic a, logic h);
        t_in rq;
        rq.cmd            = cmd;
        rq.timer_id       = id;
        rq.group          = grp;
        rq.now_fine       = tick_fine;
        rq.now_coarse     = tick_coarse;
        rq.period         = per;
        rq.is_periodic    = p;
        rq.is_absolute    = a;
        rq.has_action     = h;
        rq.shift_positive = 1'($urandom);
        rq.shift_fine     = $urandom_range(0, 30);
        rq.shift_coarse   = $urandom_range(0, 30);
        return rq;
    endfunction

    function automatic logic [31:0] pick_period();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(0, 40);
        if (r < 90) return $urandom_range(0, 1000);
        return $urandom;
    endfunction

    function automatic t_in random_req();
        int   w;
        t_in  rq;
        logic [2:0] cmd;
        w = $urandom_range(99);
        if (w < 20) cmd = CMD_CFG;
        else if (w < 45) cmd = CMD_START;
        else if (w < 55) cmd = CMD_STOP;
        else if (w < 87) cmd = CMD_CHECK;
        else if (w < 96) cmd = CMD_SHIFT;
        else cmd = 3'($urandom_range(5, 7));
        rq = mk_req(cmd, 4'($urandom), 1'($urandom), pick_period(),
                    1'($urandom), 1'($urandom), 1'($urandom));
        if ($urandom_range(9) == 0) begin
            rq.shift_fine   = $urandom;
            rq.shift_coarse = $urandom;
        end
        return rq;
    endfunction

    // let time move on, with rare jumps anywhere
    task automatic advance_time();
        if ($urandom_range(19) == 0) begin
            tick_fine   = $urandom;
            tick_coarse = $urandom;
        end else begin
            tick_fine   += $urandom_range(0, 20);
            tick_coarse += $urandom_range(0, 5);
        end
    endtask

    task automatic random_burst(int n);
        for (int k = 0; k < n; k++) begin
            advance_time();
            send_req(random_req());
        end
    endtask

    // directed cases: empty groups, zero and max periods, ignored requests
    task automatic directed_run();
        t_in rq;
        send_req(mk_req(CMD_CHECK, 4'd0, 1'b0, 0, 0, 0, 0));
        send_req(mk_req(CMD_CHECK, 4'd0, 1'b1, 0, 0, 0, 0));
        send_req(mk_req(CMD_CFG, 4'd0, 1'b0, 32'd0, 1, 1, 1));
        send_req(mk_req(CMD_START, 4'd0, 1'b0, 0, 0, 0, 0));
        send_req(mk_req(CMD_START, 4'd0, 1'b0, 0, 0, 0, 0));
        send_req(mk_req(CMD_CFG, 4'd0, 1'b1, 32'd7, 0, 0, 0));
        tick_coarse = 32'hFFFF_FFFF;
        send_req(mk_req(CMD_CFG, 4'd15, 1'b1, 32'hFFFF_FFFF, 0, 1, 1));
        send_req(mk_req(CMD_START, 4'd15, 1'b0, 0, 0, 0, 0));
        send_req(mk_req(CMD_CFG, 4'd1, 1'b0, 32'd5, 0, 0, 1));
        send_req(mk_req(CMD_START, 4'd1, 1'b0, 0, 0, 0, 0));
        send_req(mk_req(CMD_CFG, 4'd2, 1'b0, 32'd5, 0, 0, 0));
        send_req(mk_req(CMD_START, 4'd2, 1'b0, 0, 0, 0, 0));
        send_req(mk_req(CMD_STOP, 4'd3, 1'b0, 0, 0, 0, 0));
        tick_fine += 10;
        send_req(mk_req(CMD_CHECK, 4'd0, 1'b0, 0, 0, 0, 0));
        send_req(mk_req(CMD_STOP, 4'd15, 1'b1, 0, 0, 0, 0));
        send_req(mk_req(CMD_STOP, 4'd0, 1'b0, 0, 0, 0, 0));
        rq = mk_req(CMD_SHIFT, 4'd0, 1'b0, 0, 0, 0, 0);
        rq.shift_positive = 1'b1;
        rq.shift_fine     = 32'hFFFF_FFFF;
        rq.shift_coarse   = 32'hFFFF_FFFF;
        send_req(rq);
        rq.shift_positive = 1'b0;
        send_req(rq);
        send_req(mk_req(3'd5, 4'd4, 1'b0, 0, 0, 0, 0));
        send_req(mk_req(3'd6, 4'd4, 1'b1, 0, 0, 0, 0));
        send_req(mk_req(3'd7, 4'd4, 1'b1, 0, 0, 0, 0));
        send_req(mk_req(CMD_CHECK, 4'd0, 1'b1, 0, 0, 0, 0));
    endtask

    // stimulus and verdict
    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_min_delays(MIN_FINE_RST, MIN_COARSE_RST);
        directed_run();
        random_burst(30);
        // long receiver hold-off while requests keep coming
        hold_seq++;
        random_burst(20);

        write_min_delays(16'd1, 16'd65535);
        idle_pct  = 61;
        stall_pct = 0;
        random_burst(50);

        write_min_delays(16'd65535, 16'd0);
        idle_pct  = 0;
        stall_pct = 61;
        random_burst(25);
        drain();
        random_burst(25);

        write_min_delays(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)));
        idle_pct  = 16;
        stall_pct = 16;
        random_burst(50);

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS multi_timer_deadline_scheduler_unit");
        end else begin
            $display("FAIL multi_timer_deadline_scheduler_unit");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/mtds_pkg.sv
rtl/mtds_mod.sv
rtl/mtds_cell.sv
rtl/multi_timer_deadline_scheduler_unit.sv
tb/mtds_sched_checker.sv
tb/testbench.sv
